FILE: sv/assert_macros.svh
// Assertion macros for the line follower RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define TSLF_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define TSLF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/tslf_pkg.sv
// Types, register indexes and reset values for the line follower.
`default_nettype none

package tslf_pkg;

    localparam int READING_W = 7;
    localparam int GAIN_W    = 10;
    localparam int POWER_W   = 8;
    localparam int IDX_W     = 3;
    localparam int CFG_W     = 10;

    // Register indexes
    localparam logic [IDX_W-1:0] REG_THRESHOLD    = 3'd0;
    localparam logic [IDX_W-1:0] REG_PROP_GAIN    = 3'd1;
    localparam logic [IDX_W-1:0] REG_DERIV_GAIN   = 3'd2;
    localparam logic [IDX_W-1:0] REG_SIDE_GAIN    = 3'd3;
    localparam logic [IDX_W-1:0] REG_CRUISE_POWER = 3'd4;
    localparam logic [IDX_W-1:0] REG_SEARCH_MAG   = 3'd5;

    // Reset values
    localparam logic [READING_W-1:0]      RST_THRESHOLD    = 7'd40;
    localparam logic [GAIN_W-1:0]         RST_PROP_GAIN    = 10'd166;
    localparam logic [GAIN_W-1:0]         RST_DERIV_GAIN   = 10'd77;
    localparam logic [GAIN_W-1:0]         RST_SIDE_GAIN    = 10'd90;
    localparam logic signed [POWER_W-1:0] RST_CRUISE_POWER = 8'sd50;
    localparam logic [POWER_W-1:0]        RST_SEARCH_MAG   = 8'd60;

    localparam logic signed [POWER_W-1:0] POWER_MAX = 8'sd100;
    localparam logic signed [POWER_W-1:0] POWER_MIN = -8'sd100;

    typedef struct packed {
        logic [READING_W-1:0]      threshold;
        logic [GAIN_W-1:0]         prop_gain;
        logic [GAIN_W-1:0]         deriv_gain;
        logic [GAIN_W-1:0]         side_gain;
        logic signed [POWER_W-1:0] cruise_power;
        logic [POWER_W-1:0]        search_mag;
    } cfg_t;

    typedef struct packed {
        logic [READING_W-1:0] left_reading;
        logic [READING_W-1:0] middle_reading;
        logic [READING_W-1:0] right_reading;
    } sample_t;

    typedef struct packed {
        logic signed [POWER_W-1:0] lmotor_pwr;
        logic signed [POWER_W-1:0] rmotor_pwr;
        logic signed [POWER_W-1:0] middle_error;
        logic                      off_track;
    } result_t;

endpackage

`default_nettype wire

FILE: sv/tslf_cfg.sv
// Configuration register bank for the line follower.
`default_nettype none

module tslf_cfg
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        wr_en,
    input  wire logic [tslf_pkg::IDX_W-1:0]  wr_index,
    input  wire logic [tslf_pkg::CFG_W-1:0]  wr_data,
    output tslf_pkg::cfg_t                   cfg
);

    tslf_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.threshold    <= tslf_pkg::RST_THRESHOLD;
            cfg_reg.prop_gain    <= tslf_pkg::RST_PROP_GAIN;
            cfg_reg.deriv_gain   <= tslf_pkg::RST_DERIV_GAIN;
            cfg_reg.side_gain    <= tslf_pkg::RST_SIDE_GAIN;
            cfg_reg.cruise_power <= tslf_pkg::RST_CRUISE_POWER;
            cfg_reg.search_mag   <= tslf_pkg::RST_SEARCH_MAG;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                tslf_pkg::REG_THRESHOLD:    cfg_reg.threshold    <= wr_data[6:0];
                tslf_pkg::REG_PROP_GAIN:    cfg_reg.prop_gain    <= wr_data;
                tslf_pkg::REG_DERIV_GAIN:   cfg_reg.deriv_gain   <= wr_data;
                tslf_pkg::REG_SIDE_GAIN:    cfg_reg.side_gain    <= wr_data;
                tslf_pkg::REG_CRUISE_POWER: cfg_reg.cruise_power <= $signed(wr_data[7:0]);
                tslf_pkg::REG_SEARCH_MAG:   cfg_reg.search_mag   <= wr_data[7:0];
                default:                    ; // unmapped index, write dropped
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

FILE: sv/tslf_core.sv
// PD steering arithmetic and tracking state for one sample.
`default_nettype none

module tslf_core
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire tslf_pkg::cfg_t    cfg,
    input  wire tslf_pkg::sample_t smp,
    input  wire logic              step,
    output tslf_pkg::result_t      result,
    output logic                   line_to_left
);

    logic signed [7:0]  prev_err_reg;
    logic signed [7:0]  prev_err_next;
    logic               line_to_left_reg;
    logic               line_to_left_next;

    logic [6:0]         l;
    logic [6:0]         m;
    logic [6:0]         r;
    logic [6:0]         th;
    logic signed [7:0]  err;
    logic signed [8:0]  err_diff;
    logic signed [7:0]  lr_delta;
    logic signed [18:0] p_prod;
    logic signed [19:0] d_prod;
    logic signed [18:0] s_prod;
    logic signed [20:0] pd_sum;
    logic               round_up;
    logic signed [12:0] corr_pd;
    logic signed [12:0] corr;
    logic signed [13:0] left_sum;
    logic signed [13:0] right_sum;
    logic               lost;

    function automatic logic signed [7:0] sat_power(input logic signed [13:0] v);
        logic signed [7:0] res;
        if (v > 14'(tslf_pkg::POWER_MAX))
            res = tslf_pkg::POWER_MAX;
        else if (v < 14'(tslf_pkg::POWER_MIN))
            res = tslf_pkg::POWER_MIN;
        else
            res = v[7:0];
        return res;
    endfunction

    always_comb
    begin
        l  = smp.left_reading;
        m  = smp.middle_reading;
        r  = smp.right_reading;
        th = cfg.threshold;

        err      = {1'b0, m} - {1'b0, th};
        err_diff = {err[7], err} - {prev_err_reg[7], prev_err_reg};
        lr_delta = {1'b0, l} - {1'b0, r};
        lost     = (l > th) && (m > th) && (r > th);

        p_prod = $signed({1'b0, cfg.prop_gain})  * err;
        d_prod = $signed({1'b0, cfg.deriv_gain}) * err_diff;
        s_prod = $signed({1'b0, cfg.side_gain})  * lr_delta;
        pd_sum = 21'(p_prod) + 21'(d_prod) + 21'(s_prod);

        // divide by 256 rounding toward zero
        round_up = pd_sum[20] && (|pd_sum[7:0]);
        corr_pd  = pd_sum[20:8] + {12'd0, round_up};

        if (lost)
            corr = line_to_left_reg ? 13'd0 - {5'd0, cfg.search_mag}
                                    : {5'd0, cfg.search_mag};
        else
            corr = corr_pd;

        left_sum  = 14'(cfg.cruise_power) + 14'(corr);
        right_sum = 14'(cfg.cruise_power) - 14'(corr);

        result.lmotor_pwr   = sat_power(left_sum);
        result.rmotor_pwr   = sat_power(right_sum);
        result.middle_error = err;
        result.off_track    = lost;

        prev_err_next = err;
        priority if (err != 8'sd0)
            line_to_left_next = err[7];
        else if (l < th)
            line_to_left_next = 1'b1;
        else if (r < th)
            line_to_left_next = 1'b0;
        else
            line_to_left_next = line_to_left_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_err_reg     <= 8'sd0;
            line_to_left_reg <= 1'b0;
        end
        else if (step)
        begin
            prev_err_reg     <= prev_err_next;
            line_to_left_reg <= line_to_left_next;
        end
    end

    assign line_to_left = line_to_left_reg;

endmodule

`default_nettype wire

FILE: sv/three_sensor_pd_line_follower.sv
// Top level of the three-sensor PD line follower.
//
//  channel | direction | beat contents
//  s_*     | in        | s_tdata: left[6:0], middle[13:7], right[20:14]
//  m_*     | out       | m_tdata: lmotor_pwr, rmotor_pwr, middle_error; m_tuser: off_track
//  cfg_*   | in        | cfg_index selects register, cfg_data holds the value
//
// One sample per cycle sustained while m_tready is high; an s_* beat reaches m_*
// through the input register, then the arithmetic into the result register.
// Reset restores register defaults and clears previous error and direction.
// A stall on m_tready holds the result register and backs up into the input
// register; s_tready drops only when both are full and the output is stalled.
// cfg_ready is always high.
`default_nettype none

module three_sensor_pd_line_follower
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // left_reading, middle_reading, right_reading
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // lmotor_pwr, rmotor_pwr, middle_error
    output logic [0:0]       m_tuser,   // off_track
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [9:0]  cfg_data
);

`include "assert_macros.svh"

    tslf_pkg::cfg_t    cfg;
    tslf_pkg::sample_t smp_reg;
    tslf_pkg::result_t core_res;
    tslf_pkg::result_t res_reg;
    logic              s1_valid_reg;
    logic              m_valid_reg;
    logic              advance;
    logic              step;
    logic              line_to_left;

    assign cfg_ready = 1'b1;
    assign advance   = !m_valid_reg || m_tready;
    assign s_tready  = !s1_valid_reg || advance;
    assign step      = s1_valid_reg && advance;

    tslf_cfg u_cfg
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    tslf_core u_core
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .smp          (smp_reg),
        .step         (step),
        .result       (core_res),
        .line_to_left (line_to_left)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            if (s_tready)
                s1_valid_reg <= s_tvalid;
            if (advance)
                m_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            smp_reg.left_reading   <= s_tdata[6:0];
            smp_reg.middle_reading <= s_tdata[13:7];
            smp_reg.right_reading  <= s_tdata[20:14];
        end
        if (step)
            res_reg <= core_res;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {res_reg.middle_error, res_reg.rmotor_pwr, res_reg.lmotor_pwr};
    assign m_tuser  = res_reg.off_track;

    `TSLF_ASSERT_NOW(a_no_accept_when_full, s1_valid_reg && m_valid_reg && !m_tready,
        !s_tready, "input beat taken while both stages are full")
    `TSLF_ASSERT_NEXT(a_step_fills_output, step, m_valid_reg,
        "sample left the input register but no result was shown")
    `TSLF_ASSERT_NOW(a_power_in_range, m_valid_reg,
        (res_reg.lmotor_pwr <= tslf_pkg::POWER_MAX)
        && (res_reg.lmotor_pwr >= tslf_pkg::POWER_MIN)
        && (res_reg.rmotor_pwr <= tslf_pkg::POWER_MAX)
        && (res_reg.rmotor_pwr >= tslf_pkg::POWER_MIN),
        "motor power outside saturation limits")
    `TSLF_ASSERT_NEXT(a_direction_follows_error, step && (core_res.middle_error != 8'sd0),
        line_to_left == $past(core_res.middle_error[7]),
        "direction flag disagrees with sign of last error")

endmodule

`default_nettype wire

FILE: test/tb_three_sensor_pd_line_follower.sv
// Testbench for the three-sensor PD line follower: directed table, random phases, scoreboard.
`default_nettype none

module tb_three_sensor_pd_line_follower;

    localparam logic [tslf_pkg::IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [tslf_pkg::IDX_W-1:0] REG_SPARE_HI = 3'd7;
    localparam int Q8_ONE         = 256;
    localparam int NUM_PHASES     = 9;
    localparam int ITEMS_PER_PHASE = 170;
    localparam int SETTLE_CYCLES  = 4;
    localparam int CYCLE_LIMIT    = 300000;

    typedef struct {
        logic [tslf_pkg::READING_W-1:0] left;
        logic [tslf_pkg::READING_W-1:0] middle;
        logic [tslf_pkg::READING_W-1:0] right;
        bit                             typed;
        int                             lp;
        int                             rp;
        int                             me;
        int                             lost;
    } row_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;
    logic [0:0]  m_tuser;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [9:0]  cfg_data;

    // predictor state
    tslf_pkg::cfg_t                      regs;
    logic signed [tslf_pkg::POWER_W-1:0] prev_error_q;
    bit                                  line_left_q;

    tslf_pkg::result_t pending_results[$];
    int                mismatches;
    int                cycle_count;
    int                src_idle_pct;
    int                snk_idle_pct;
    row_t              dir_rows [19];

    three_sensor_pd_line_follower DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int clamp_power(int v);
        if (v > int'(tslf_pkg::POWER_MAX))
            return int'(tslf_pkg::POWER_MAX);
        if (v < int'(tslf_pkg::POWER_MIN))
            return int'(tslf_pkg::POWER_MIN);
        return v;
    endfunction

    function automatic void store_reg(logic [tslf_pkg::IDX_W-1:0] idx,
                                      logic [tslf_pkg::CFG_W-1:0] val);
        case (idx)
            tslf_pkg::REG_THRESHOLD:
                regs.threshold    = val[tslf_pkg::READING_W-1:0];
            tslf_pkg::REG_PROP_GAIN:
                regs.prop_gain    = val[tslf_pkg::GAIN_W-1:0];
            tslf_pkg::REG_DERIV_GAIN:
                regs.deriv_gain   = val[tslf_pkg::GAIN_W-1:0];
            tslf_pkg::REG_SIDE_GAIN:
                regs.side_gain    = val[tslf_pkg::GAIN_W-1:0];
            tslf_pkg::REG_CRUISE_POWER:
                regs.cruise_power = val[tslf_pkg::POWER_W-1:0];
            tslf_pkg::REG_SEARCH_MAG:
                regs.search_mag   = val[tslf_pkg::POWER_W-1:0];
            default: ;
        endcase
    endfunction

    // Powers for one tick; advances previous error and line side.
    function automatic tslf_pkg::result_t steer_predict(tslf_pkg::sample_t s);
        int                l, m, r, th, err, corr, sum, base;
        bit                lost;
        tslf_pkg::result_t res;
        l    = s.left_reading;
        m    = s.middle_reading;
        r    = s.right_reading;
        th   = regs.threshold;
        base = $signed(regs.cruise_power);
        err  = m - th;
        lost = (l > th) && (m > th) && (r > th);
        if (lost)
            corr = line_left_q ? -int'(regs.search_mag) : int'(regs.search_mag);
        else
        begin
            sum = int'(regs.prop_gain) * err
                + int'(regs.deriv_gain) * (err - int'(prev_error_q))
                + int'(regs.side_gain) * (l - r);
            corr = sum / Q8_ONE;    // truncates toward zero
        end
        prev_error_q = err[tslf_pkg::POWER_W-1:0];
        if (err != 0)
            line_left_q = (err < 0);
        else if (l < th)
            line_left_q = 1'b1;
        else if (r < th)
            line_left_q = 1'b0;
        res.lmotor_pwr   = 8'(clamp_power(base + corr));
        res.rmotor_pwr   = 8'(clamp_power(base - corr));
        res.middle_error = err[tslf_pkg::POWER_W-1:0];
        res.off_track    = lost;
        return res;
    endfunction

    // Mostly plausible track readings around the threshold, some lost-line runs,
    // some zero-error ticks and some full-range noise.
    function automatic tslf_pkg::sample_t pick_sample();
        tslf_pkg::sample_t s;
        int                th, k, mid;
        th = regs.threshold;
        k  = $urandom_range(99);
        s.left_reading  = 7'($urandom_range(100));
        s.right_reading = 7'($urandom_range(100));
        if (k < 15)
        begin
            s.left_reading   = 7'($urandom_range(127));
            s.middle_reading = 7'($urandom_range(127));
            s.right_reading  = 7'($urandom_range(127));
        end
        else if (k < 30 && th < 127)
        begin
            s.left_reading   = 7'($urandom_range(127, th + 1));
            s.middle_reading = 7'($urandom_range(127, th + 1));
            s.right_reading  = 7'($urandom_range(127, th + 1));
        end
        else if (k < 42)
            s.middle_reading = 7'(th);
        else
        begin
            mid = th + $urandom_range(60) - 30;
            if (mid < 0)
                mid = 0;
            if (mid > 127)
                mid = 127;
            s.middle_reading = 7'(mid);
        end
        return s;
    endfunction

    task automatic send_sample(tslf_pkg::sample_t s, bit typed, tslf_pkg::result_t typed_res);
        tslf_pkg::result_t res;
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, s.right_reading, s.middle_reading, s.left_reading};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        res = steer_predict(s);
        pending_results.push_back(typed ? typed_res : res);
    endtask

    // leaves cfg_valid high; the caller lowers it after the last write
    task automatic write_reg(logic [tslf_pkg::IDX_W-1:0] idx, logic [tslf_pkg::CFG_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        store_reg(idx, val);
    endtask

    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // upper data bits carry noise; the block must drop them
    task automatic program_phase(int ph);
        logic [tslf_pkg::CFG_W-1:0] th, kp, kd, ks, base, rec;
        int                         b;
        case (ph)
            1:
            begin
                th = 10'h380; kp = 10'h000; kd = 10'h000; ks = 10'h000;
                base = 10'h280; rec = 10'h300;
            end
            2:
            begin
                th = 10'h07F; kp = 10'h3FF; kd = 10'h3FF; ks = 10'h3FF;
                base = 10'h07F; rec = 10'h0FF;
            end
            default:
            begin
                if ($urandom_range(4) == 0)
                    th = {3'($urandom_range(7)), 7'($urandom_range(127, 101))};
                else
                    th = {3'($urandom_range(7)), 7'($urandom_range(100))};
                kp = 10'($urandom_range(1023));
                kd = 10'($urandom_range(1023));
                ks = 10'($urandom_range(1023));
                b  = ($urandom_range(4) == 0) ? $urandom_range(255) - 128
                                              : $urandom_range(200) - 100;
                base = {2'($urandom_range(3)), 8'(b)};
                rec  = {2'($urandom_range(3)), 8'($urandom_range(255))};
                write_reg(REG_SPARE_LO, 10'($urandom_range(1023)));
                write_reg(REG_SPARE_HI, 10'($urandom_range(1023)));
            end
        endcase
        write_reg(tslf_pkg::REG_THRESHOLD, th);
        write_reg(tslf_pkg::REG_PROP_GAIN, kp);
        write_reg(tslf_pkg::REG_DERIV_GAIN, kd);
        write_reg(tslf_pkg::REG_SIDE_GAIN, ks);
        write_reg(tslf_pkg::REG_CRUISE_POWER, base);
        write_reg(tslf_pkg::REG_SEARCH_MAG, rec);
        cfg_valid <= 1'b0;
    endtask

    task automatic check_field(string name, int want, int got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(99) >= snk_idle_pct);
    end

    always @(posedge clk)
    begin
        tslf_pkg::result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result beat with nothing expected");
                mismatches++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("lmotor_pwr", $signed(want.lmotor_pwr), $signed(m_tdata[7:0]));
                check_field("rmotor_pwr", $signed(want.rmotor_pwr),
                            $signed(m_tdata[15:8]));
                check_field("middle_error", $signed(want.middle_error),
                            $signed(m_tdata[23:16]));
                check_field("off_track", want.off_track, m_tuser[0]);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    initial
    begin
        tslf_pkg::sample_t s;
        tslf_pkg::result_t typed_res;
        clk          = 1'b0;
        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        m_tready     = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        mismatches   = 0;
        cycle_count  = 0;
        src_idle_pct = 8;
        snk_idle_pct = 49;
        regs.threshold    = tslf_pkg::RST_THRESHOLD;
        regs.prop_gain    = tslf_pkg::RST_PROP_GAIN;
        regs.deriv_gain   = tslf_pkg::RST_DERIV_GAIN;
        regs.side_gain    = tslf_pkg::RST_SIDE_GAIN;
        regs.cruise_power = tslf_pkg::RST_CRUISE_POWER;
        regs.search_mag   = tslf_pkg::RST_SEARCH_MAG;
        prev_error_q = '0;
        line_left_q  = 1'b0;

        // Reset defaults. Lost line steers by the last known side; a centred middle
        // takes the side from whichever side sensor is dark, or keeps it.
        dir_rows = '{
            '{127, 127, 127, 1, 100, -10, 87, 1},   // lost, side right from reset
            '{  0,   0,   0, 0, 0, 0, 0, 0},        // negative error: line to the left
            '{127, 127, 127, 1, -10, 100, 87, 1},   // lost, steer left
            '{ 10,  40, 127, 0, 0, 0, 0, 0},        // centred, left dark
            '{127, 127, 127, 0, 0, 0, 0, 0},
            '{127,  40,  10, 0, 0, 0, 0, 0},        // centred, right dark
            '{127, 127, 127, 0, 0, 0, 0, 0},
            '{  0,   0,   0, 0, 0, 0, 0, 0},
            '{ 40,  40,  40, 0, 0, 0, 0, 0},        // centred, neither dark: side held
            '{127, 127, 127, 0, 0, 0, 0, 0},
            '{ 41,  41,  41, 0, 0, 0, 0, 0},        // just lost
            '{ 40,  41,  41, 0, 0, 0, 0, 0},        // left on the boundary: not lost
            '{127,   0,   0, 0, 0, 0, 0, 0},
            '{  0,   0, 127, 0, 0, 0, 0, 0},
            '{  0, 127,   0, 0, 0, 0, 0, 0},
            '{127,   0, 127, 0, 0, 0, 0, 0},
            '{100, 100, 100, 0, 0, 0, 0, 0},
            '{  0, 127, 127, 0, 0, 0, 0, 0},
            '{100,   0, 100, 0, 0, 0, 0, 0}
        };

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            if (ph != 0)
            begin
                wait_for_results();
                program_phase(ph);
            end
            if (ph < 3)
            begin
                src_idle_pct = 8;
                snk_idle_pct = 49;
            end
            else if (ph < 6)
            begin
                src_idle_pct = 49;
                snk_idle_pct = 8;
            end
            else
            begin
                src_idle_pct = 0;
                snk_idle_pct = 0;
            end
            if (ph == 0)
            begin
                foreach (dir_rows[i])
                begin
                    s.left_reading         = dir_rows[i].left;
                    s.middle_reading       = dir_rows[i].middle;
                    s.right_reading        = dir_rows[i].right;
                    typed_res.lmotor_pwr   = 8'(dir_rows[i].lp);
                    typed_res.rmotor_pwr   = 8'(dir_rows[i].rp);
                    typed_res.middle_error = 8'(dir_rows[i].me);
                    typed_res.off_track    = dir_rows[i].lost[0];
                    send_sample(s, dir_rows[i].typed, typed_res);
                end
            end
            repeat (ITEMS_PER_PHASE) send_sample(pick_sample(), 1'b0, '0);
        end
        wait_for_results();
        repeat (10) @(posedge clk);

        if (pending_results.size() != 0)
        begin
            $error("%0d expected results never arrived", pending_results.size());
            mismatches++;
        end
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

`default_nettype wire

FILE: three_sensor_pd_line_follower.f
+incdir+sv
sv/tslf_pkg.sv
sv/tslf_cfg.sv
sv/tslf_core.sv
sv/three_sensor_pd_line_follower.sv
test/tb_three_sensor_pd_line_follower.sv
